FILE: rtl/core/fcfh_pkg.sv
`default_nettype none

package fcfh_pkg;

  // frame store geometry
  localparam int unsigned FRAME_BYTES = 5;
  localparam int unsigned IDX_W       = 3;

  // frame bytes
  localparam logic [7:0] BYTE_STX        = 8'h02;
  localparam logic [7:0] BYTE_ETX        = 8'h03;
  localparam logic [7:0] BYTE_STATUS_REQ = 8'h04;
  localparam logic [7:0] BYTE_REPLY_FLAG = 8'h80;
  localparam logic [7:0] BYTE_LEN_ONE    = 8'h01;
  localparam logic [7:0] BYTE_LEN_STATUS = 8'h04;
  localparam logic [7:0] BYTE_STATUS_ID  = 8'h84;

  // commands
  localparam logic [7:0] CMD_POWER = 8'h01;
  localparam logic [7:0] CMD_MODE  = 8'h02;
  localparam logic [7:0] CMD_SPEED = 8'h03;

  // reply codes
  localparam logic [7:0] RC_OK      = 8'h00;
  localparam logic [7:0] RC_BAD     = 8'h01;
  localparam logic [7:0] RC_REFUSED = 8'h02;
  localparam logic [7:0] RC_BAD_LEN = 8'hff;

  // sample classes in the status reply
  localparam logic [7:0] CLASS_LOW  = 8'h00;
  localparam logic [7:0] CLASS_MID  = 8'h01;
  localparam logic [7:0] CLASS_HIGH = 8'hff;

  // run modes
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  // fan levels
  localparam logic [1:0] LEVEL_ZERO = 2'd0;
  localparam logic [1:0] LEVEL_ONE  = 2'd1;
  localparam logic [1:0] LEVEL_TWO  = 2'd2;

  // config register reset values
  localparam logic [7:0] LOW_THR_RST   = 8'd100;
  localparam logic [7:0] HIGH_THR_RST  = 8'd200;
  localparam logic [7:0] DUTY_LOW_RST  = 8'd0;
  localparam logic [7:0] DUTY_MID_RST  = 8'd4;
  localparam logic [7:0] DUTY_HIGH_RST = 8'd9;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR    = 3'd0,
    CFG_HIGH_THR   = 3'd1,
    CFG_DUTY_LOW   = 3'd2,
    CFG_DUTY_MID   = 3'd3,
    CFG_DUTY_HIGH  = 3'd4,
    CFG_SPEED_MAN  = 3'd5,
    CFG_STATUS_RAW = 3'd6
  } cfg_reg_e;

  localparam int unsigned REPLY_MAX = 8;
  localparam int unsigned BEAT_W    = 3;

  // everything the serializer needs for the results of one item
  typedef struct packed {
    logic                          has_reply;
    logic [BEAT_W-1:0]             last_beat;
    logic [REPLY_MAX-1:0][7:0]     bytes;
    logic [1:0]                    level;
    logic [7:0]                    duty;
    logic [1:0]                    mode;
  } reply_t;

endpackage

`default_nettype wire

FILE: rtl/core/fcfh_ctrl.sv
`default_nettype none

module fcfh_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcfh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  input  wire logic                         accept_i,
  input  wire logic                         action_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic [7:0]                   adc_sample_i,
  output fcfh_pkg::reply_t                  reply_o
);
  import fcfh_pkg::*;

  logic [7:0] low_thr_q, high_thr_q, duty_low_q, duty_mid_q, duty_high_q;
  logic       speed_man_q, status_raw_q;

  logic [7:0]       store_q [FRAME_BYTES];
  logic [7:0]       store_d [FRAME_BYTES];
  logic [IDX_W-1:0] widx_q, widx_d;
  logic [1:0]       mode_q, mode_d;
  logic [1:0]       level_q, level_d;
  logic [7:0]       sample_q, sample_d;

  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx_inc;
  logic [7:0]       cmd, len, dat, code, cls;
  reply_t           rep;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q    <= LOW_THR_RST;
      high_thr_q   <= HIGH_THR_RST;
      duty_low_q   <= DUTY_LOW_RST;
      duty_mid_q   <= DUTY_MID_RST;
      duty_high_q  <= DUTY_HIGH_RST;
      speed_man_q  <= 1'b1;
      status_raw_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LOW_THR:    low_thr_q    <= cfg_data_i;
        CFG_HIGH_THR:   high_thr_q   <= cfg_data_i;
        CFG_DUTY_LOW:   duty_low_q   <= cfg_data_i;
        CFG_DUTY_MID:   duty_mid_q   <= cfg_data_i;
        CFG_DUTY_HIGH:  duty_high_q  <= cfg_data_i;
        CFG_SPEED_MAN:  speed_man_q  <= cfg_data_i[0];
        CFG_STATUS_RAW: status_raw_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    store_d  = store_q;
    widx_d   = widx_q;
    mode_d   = mode_q;
    level_d  = level_q;
    sample_d = sample_q;
    rep      = '0;
    code     = RC_OK;
    cls      = CLASS_LOW;
    idx      = widx_q;
    idx_inc  = '0;
    cmd      = '0;
    len      = '0;
    dat      = '0;

    if (accept_i) begin
      if (action_i) begin
        sample_d = adc_sample_i;
        if (mode_q == MODE_AUTO) begin
          // crossed thresholds: the first test wins, so low band takes priority
          if (adc_sample_i < low_thr_q) begin
            level_d = LEVEL_ZERO;
          end else if (adc_sample_i < high_thr_q) begin
            level_d = LEVEL_ONE;
          end else begin
            level_d = LEVEL_TWO;
          end
        end
      end else begin
        if ({1'b0, widx_q} >= (IDX_W+1)'(FRAME_BYTES)) begin
          idx = '0;
        end
        store_d[idx] = rx_byte_i;
        idx_inc = {1'b0, idx} + 1'b1;
        if (idx_inc >= (IDX_W+1)'(FRAME_BYTES)) begin
          widx_d = '0;
        end else begin
          widx_d = idx_inc[IDX_W-1:0];
        end

        // command frame
        if (store_d[4] == BYTE_ETX) begin
          widx_d     = '0;
          store_d[4] = '0;
          cmd = store_d[1];
          len = store_d[2];
          dat = store_d[3];
          if (cmd == CMD_POWER || cmd == CMD_MODE || cmd == CMD_SPEED) begin
            if (len != BYTE_LEN_ONE) begin
              code = RC_BAD_LEN;
            end else begin
              case (cmd)
                CMD_POWER: begin
                  if (dat == 8'd1) begin
                    mode_d  = MODE_MANUAL;
                    level_d = LEVEL_TWO;
                  end else if (dat == 8'd0) begin
                    mode_d  = MODE_OFF;
                    level_d = LEVEL_ZERO;
                  end else begin
                    code = RC_BAD;
                  end
                end
                CMD_MODE: begin
                  if (dat > 8'd1) begin
                    code = RC_BAD;
                  end else if (mode_q == MODE_OFF) begin
                    code = RC_REFUSED;
                  end else begin
                    mode_d = dat[0] ? MODE_MANUAL : MODE_AUTO;
                  end
                end
                default: begin
                  if (dat > 8'd2) begin
                    code = RC_BAD;
                  end else if (mode_q == MODE_OFF) begin
                    code = RC_REFUSED;
                  end else begin
                    level_d = dat[1:0];
                    if (speed_man_q) mode_d = MODE_MANUAL;
                  end
                end
              endcase
            end
            rep.has_reply = 1'b1;
            rep.last_beat = BEAT_W'(4);
            rep.bytes[0]  = BYTE_STX;
            rep.bytes[1]  = BYTE_REPLY_FLAG | cmd;
            rep.bytes[2]  = BYTE_LEN_ONE;
            rep.bytes[3]  = code;
            rep.bytes[4]  = BYTE_ETX;
          end
        end

        // status request, checked on the store as the command check left it
        if (store_d[1] == BYTE_STATUS_REQ && store_d[3] == BYTE_ETX) begin
          widx_d     = '0;
          store_d[3] = '0;
          rep.has_reply = 1'b1;
          rep.bytes     = '0;
          rep.bytes[0]  = BYTE_STX;
          rep.bytes[1]  = BYTE_STATUS_ID;
          if (store_d[2] != 8'h00) begin
            rep.last_beat = BEAT_W'(4);
            rep.bytes[2]  = BYTE_LEN_ONE;
            rep.bytes[3]  = RC_BAD_LEN;
            rep.bytes[4]  = BYTE_ETX;
          end else begin
            if (status_raw_q) begin
              cls = sample_q;
            end else if (sample_q < high_thr_q && sample_q >= low_thr_q) begin
              cls = CLASS_MID;
            end else if (sample_q >= high_thr_q) begin
              cls = CLASS_HIGH;
            end else begin
              cls = CLASS_LOW;
            end
            rep.last_beat = BEAT_W'(7);
            rep.bytes[2]  = BYTE_LEN_STATUS;
            rep.bytes[3]  = 8'h00;
            rep.bytes[4]  = {6'd0, mode_d};
            rep.bytes[5]  = {6'd0, level_d};
            rep.bytes[6]  = cls;
            rep.bytes[7]  = BYTE_ETX;
          end
        end
      end
    end

    rep.level = level_d;
    rep.mode  = mode_d;
    case (level_d)
      LEVEL_ZERO: rep.duty = duty_low_q;
      LEVEL_ONE:  rep.duty = duty_mid_q;
      default:    rep.duty = duty_high_q;
    endcase
  end

  assign reply_o = rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) store_q[i] <= '0;
      widx_q   <= '0;
      mode_q   <= MODE_OFF;
      level_q  <= LEVEL_ZERO;
      sample_q <= '0;
    end else begin
      store_q  <= store_d;
      widx_q   <= widx_d;
      mode_q   <= mode_d;
      level_q  <= level_d;
      sample_q <= sample_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fcfh_ser.sv
`default_nettype none

module fcfh_ser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire fcfh_pkg::reply_t reply_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             take_i,
  output logic                  tx_valid_o,
  output logic [7:0]            tx_byte_o,
  output logic                  last_o,
  output logic [1:0]            fan_level_o,
  output logic [7:0]            fan_duty_o,
  output logic [1:0]            run_mode_o
);
  import fcfh_pkg::*;

  logic              valid_q;
  logic [BEAT_W-1:0] cnt_q;
  reply_t            rep_q;
  logic              at_last;

  assign at_last = (cnt_q == rep_q.last_beat);
  // free once the final beat of the held item leaves
  assign ready_o = !valid_q || (take_i && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (valid_q && take_i) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) rep_q <= reply_i;
  end

  assign valid_o     = valid_q;
  assign tx_valid_o  = rep_q.has_reply;
  assign tx_byte_o   = rep_q.bytes[cnt_q];
  assign last_o      = at_last;
  assign fan_level_o = rep_q.level;
  assign fan_duty_o  = rep_q.duty;
  assign run_mode_o  = rep_q.mode;

endmodule

`default_nettype wire

FILE: rtl/core/fan_command_frame_handler_core.sv
`default_nettype none
// The first result is registered, in the cycle after the item is accepted. Throughput,
// when the sink does not stall: one item per cycle if each gives one result; an item
// with a reply holds the result register for its 5 or 8 reply bytes, one per cycle.
// The next item is taken in the cycle the final result of the previous one leaves.
// Reset: mode off, level zero, frame store, index and sample cleared, config at defaults.

module fan_command_frame_handler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fcfh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  // input items
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [15:0]                  s_axis_tdata_i,  // rx_byte, adc_sample
  input  wire logic                         s_axis_tuser_i,  // action
  // result items
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tx_valid, tx_byte, fan_level, fan_duty, run_mode, zero pad
  output logic [23:0]                       m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import fcfh_pkg::*;

  logic   accept;
  logic   ser_ready;
  reply_t reply;
  logic   tx_valid;
  logic [7:0] tx_byte;
  logic [1:0] fan_level;
  logic [7:0] fan_duty;
  logic [1:0] run_mode;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ser_ready;
  assign accept          = s_axis_tvalid_i && ser_ready;

  fcfh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .action_i     (s_axis_tuser_i),
    .rx_byte_i    (s_axis_tdata_i[7:0]),
    .adc_sample_i (s_axis_tdata_i[15:8]),
    .reply_o      (reply)
  );

  fcfh_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .reply_i     (reply),
    .ready_o     (ser_ready),
    .valid_o     (m_axis_tvalid_o),
    .take_i      (m_axis_tready_i),
    .tx_valid_o  (tx_valid),
    .tx_byte_o   (tx_byte),
    .last_o      (m_axis_tlast_o),
    .fan_level_o (fan_level),
    .fan_duty_o  (fan_duty),
    .run_mode_o  (run_mode)
  );

  assign m_axis_tdata_o = {3'b000, run_mode, fan_duty, fan_level, tx_byte, tx_valid};

endmodule

`default_nettype wire

FILE: tb/sv/fan_command_frame_handler_core_tb.sv
module fan_command_frame_handler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcfh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 56;
  localparam int GAP_MAX     = 12;

  typedef enum logic {
    ACT_BYTE   = 1'b0,
    ACT_SAMPLE = 1'b1
  } act_e;

  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] level;
    logic [7:0] duty;
    logic [1:0] mode;
  } fan_result_t;

  // chk rows carry the reply code and run mode read straight off the frame
  typedef struct {
    act_e       act;
    logic [7:0] val;
    bit         chk;
    logic [7:0] code;
    logic [1:0] mode;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // predictor state
  logic [7:0] frame_mem [FRAME_BYTES];
  int         wr_ptr;
  logic [1:0] mode_q;
  logic [1:0] level_q;
  logic [7:0] sample_q;
  logic [7:0] lo_thr, hi_thr, duty_lo, duty_mid, duty_hi;
  logic       speed_man, raw_sample;
  logic [7:0] last_code;

  fan_result_t reply_q[$];
  int          fail_cnt;
  bit          tx_gapless;
  bit          rx_gapless;

  dir_row_t dir_rows [25] = '{
    '{ACT_SAMPLE, 8'h00,           1'b0, RC_OK,      MODE_OFF},
    // status request on a fresh store
    '{ACT_BYTE,   BYTE_STX,        1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_STATUS_REQ, 1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   8'h00,           1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_ETX,        1'b1, RC_OK,      MODE_OFF},
    // mode change refused while off
    '{ACT_BYTE,   BYTE_STX,        1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   CMD_MODE,        1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_LEN_ONE,    1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   8'h00,           1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_ETX,        1'b1, RC_REFUSED, MODE_OFF},
    // power on
    '{ACT_BYTE,   BYTE_STX,        1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   CMD_POWER,       1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_LEN_ONE,    1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   8'h01,           1'b0, RC_OK,      MODE_OFF},
    '{ACT_BYTE,   BYTE_ETX,        1'b1, RC_OK,      MODE_MANUAL},
    // switch to auto
    '{ACT_BYTE,   BYTE_STX,        1'b0, RC_OK,      MODE_MANUAL},
    '{ACT_BYTE,   CMD_MODE,        1'b0, RC_OK,      MODE_MANUAL},
    '{ACT_BYTE,   BYTE_LEN_ONE,    1'b0, RC_OK,      MODE_MANUAL},
    '{ACT_BYTE,   8'h00,           1'b0, RC_OK,      MODE_MANUAL},
    '{ACT_BYTE,   BYTE_ETX,        1'b1, RC_OK,      MODE_AUTO},
    '{ACT_SAMPLE, 8'hff,           1'b0, RC_OK,      MODE_AUTO},
    // status request with nonzero length byte
    '{ACT_BYTE,   BYTE_STX,        1'b0, RC_OK,      MODE_AUTO},
    '{ACT_BYTE,   BYTE_STATUS_REQ, 1'b0, RC_OK,      MODE_AUTO},
    '{ACT_BYTE,   8'hff,           1'b0, RC_OK,      MODE_AUTO},
    '{ACT_BYTE,   BYTE_ETX,        1'b1, RC_BAD_LEN, MODE_AUTO}
  };

  fan_command_frame_handler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] duty_for(input logic [1:0] lvl);
    case (lvl)
      LEVEL_ZERO: return duty_lo;
      LEVEL_ONE:  return duty_mid;
      default:    return duty_hi;
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [7:0] exp, input logic [7:0] got);
    if (exp !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
      fail_cnt++;
    end
  endtask

  // updates the fan state for one item and queues the results it causes
  task automatic predict_item(input act_e act, input logic [7:0] val);
    logic [7:0]  rep [8];
    int          rep_len;
    logic [7:0]  cmd, len, dat, cls;
    logic        is_off;
    fan_result_t r;
    rep_len = 0;
    if (act == ACT_SAMPLE) begin
      sample_q = val;
      if (mode_q == MODE_AUTO) begin
        if (val >= hi_thr) level_q = LEVEL_TWO;
        if (val < hi_thr && val >= lo_thr) level_q = LEVEL_ONE;
        if (val < lo_thr) level_q = LEVEL_ZERO;
      end
    end else begin
      frame_mem[wr_ptr] = val;
      wr_ptr = (wr_ptr == FRAME_BYTES - 1) ? 0 : wr_ptr + 1;
      if (frame_mem[4] == BYTE_ETX) begin
        wr_ptr = 0;
        frame_mem[4] = 8'h00;
        cmd = frame_mem[1];
        len = frame_mem[2];
        dat = frame_mem[3];
        is_off = (mode_q == MODE_OFF);
        if (cmd >= CMD_POWER && cmd <= CMD_SPEED) begin
          rep_len = 5;
          rep[0] = BYTE_STX;
          rep[1] = BYTE_REPLY_FLAG | cmd;
          rep[2] = BYTE_LEN_ONE;
          rep[4] = BYTE_ETX;
          if (len != BYTE_LEN_ONE) begin
            rep[3] = RC_BAD_LEN;
          end else if (cmd == CMD_POWER) begin
            if (dat == 8'd1) begin
              mode_q = MODE_MANUAL;
              level_q = LEVEL_TWO;
              rep[3] = RC_OK;
            end else if (dat == 8'd0) begin
              mode_q = MODE_OFF;
              level_q = LEVEL_ZERO;
              rep[3] = RC_OK;
            end else begin
              rep[3] = RC_BAD;
            end
          end else if (dat > ((cmd == CMD_MODE) ? 8'd1 : 8'd2)) begin
            rep[3] = RC_BAD;
          end else if (is_off) begin
            rep[3] = RC_REFUSED;
          end else begin
            rep[3] = RC_OK;
            if (cmd == CMD_MODE) begin
              mode_q = dat[0] ? MODE_MANUAL : MODE_AUTO;
            end else begin
              level_q = dat[1:0];
              if (speed_man) mode_q = MODE_MANUAL;
            end
          end
        end
      end
      // looks at the store as the command check left it
      if (frame_mem[1] == BYTE_STATUS_REQ && frame_mem[3] == BYTE_ETX) begin
        wr_ptr = 0;
        frame_mem[3] = 8'h00;
        rep[0] = BYTE_STX;
        rep[1] = BYTE_STATUS_ID;
        if (frame_mem[2] != 8'h00) begin
          rep_len = 5;
          rep[2] = BYTE_LEN_ONE;
          rep[3] = RC_BAD_LEN;
          rep[4] = BYTE_ETX;
        end else begin
          cls = CLASS_LOW;
          if (sample_q < lo_thr) cls = CLASS_LOW;
          if (sample_q >= hi_thr) cls = CLASS_HIGH;
          if (sample_q < hi_thr && sample_q >= lo_thr) cls = CLASS_MID;
          rep_len = 8;
          rep[2] = BYTE_LEN_STATUS;
          rep[3] = 8'h00;
          rep[4] = {6'd0, mode_q};
          rep[5] = {6'd0, level_q};
          rep[6] = raw_sample ? sample_q : cls;
          rep[7] = BYTE_ETX;
        end
      end
    end
    last_code = (rep_len > 0) ? rep[3] : 8'h00;
    r.level = level_q;
    r.duty  = duty_for(level_q);
    r.mode  = mode_q;
    if (rep_len == 0) begin
      r.tx_valid = 1'b0;
      r.tx_byte  = 8'h00;
      r.last     = 1'b1;
      reply_q.push_back(r);
    end
    for (int k = 0; k < rep_len; k++) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = rep[k];
      r.last     = (k == rep_len - 1);
      reply_q.push_back(r);
    end
  endtask

  task automatic send_item(input act_e act, input logic [7:0] val);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = act;
    // the field that the action does not use gets random content
    if (act == ACT_SAMPLE) s_axis_tdata_i = {val, 8'($urandom())};
    else                   s_axis_tdata_i = {8'($urandom()), val};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_item(act, val);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (reply_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOW_THR:    lo_thr = val;
      CFG_HIGH_THR:   hi_thr = val;
      CFG_DUTY_LOW:   duty_lo = val;
      CFG_DUTY_MID:   duty_mid = val;
      CFG_DUTY_HIGH:  duty_hi = val;
      CFG_SPEED_MAN:  speed_man = val[0];
      CFG_STATUS_RAW: raw_sample = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result sink with per-item stall
  initial begin : sink
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall = rx_gapless ? 0 : $urandom_range(0, GAP_MAX);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    fan_result_t exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result item: tdata 0x%0h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        exp = reply_q.pop_front();
        cmp_field("tx_valid", exp.tx_valid, m_axis_tdata_o[0]);
        cmp_field("tx_byte", exp.tx_byte, m_axis_tdata_o[8:1]);
        cmp_field("last", exp.last, m_axis_tlast_o);
        cmp_field("fan_level", exp.level, m_axis_tdata_o[10:9]);
        cmp_field("fan_duty", exp.duty, m_axis_tdata_o[18:11]);
        cmp_field("run_mode", exp.mode, m_axis_tdata_o[20:19]);
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("FAIL fan_command_frame_handler_core");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] cfg_vals [7];
    logic [7:0] frm [$];
    logic [7:0] cmd, dat;
    int         sel, sent;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_LOW_THR;
    cfg_data_i      = 8'h00;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 16'h0000;
    s_axis_tuser_i  = ACT_BYTE;
    fail_cnt        = 0;
    tx_gapless      = 1'b0;
    rx_gapless      = 1'b0;

    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    wr_ptr     = 0;
    mode_q     = MODE_OFF;
    level_q    = LEVEL_ZERO;
    sample_q   = 8'h00;
    lo_thr     = LOW_THR_RST;
    hi_thr     = HIGH_THR_RST;
    duty_lo    = DUTY_LOW_RST;
    duty_mid   = DUTY_MID_RST;
    duty_hi    = DUTY_HIGH_RST;
    speed_man  = 1'b1;
    raw_sample = 1'b0;
    last_code  = 8'h00;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].val);
      if (dir_rows[i].chk) begin
        cmp_field("reply code", dir_rows[i].code, last_code);
        cmp_field("run_mode", dir_rows[i].mode, mode_q);
      end
    end

    for (int phase = 1; phase <= 4; phase++) begin
      drain();
      case (phase)
        1: cfg_vals = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        2: cfg_vals = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        // thresholds crossed, low above high
        3: cfg_vals = '{8'd200, 8'd50, 8'($urandom()), 8'($urandom()),
                        8'($urandom()), 8'h00, 8'h01};
        default: foreach (cfg_vals[i]) cfg_vals[i] = 8'($urandom());
      endcase
      for (int i = 0; i < 7; i++) write_reg(cfg_reg_e'(i), cfg_vals[i]);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) begin
          tx_gapless = $urandom_range(0, 1);
          rx_gapless = $urandom_range(0, 1);
        end
        frm.delete();
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          // frame, mostly well-formed; pad with zeros so it starts at slot 0
          while (wr_ptr != 0) begin
            send_item(ACT_BYTE, 8'h00);
            sent++;
          end
          if (sel < 35) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4:          cmd = CMD_POWER;
              5, 6, 7, 8, 9, 10:      cmd = CMD_MODE;
              11, 12, 13, 14, 15, 16: cmd = CMD_SPEED;
              17:                     cmd = 8'h00;
              default:                cmd = 8'($urandom());
            endcase
            if (cmd == CMD_POWER && $urandom_range(0, 9) < 7) dat = 8'd1;
            else if ($urandom_range(0, 9) < 8) dat = 8'($urandom_range(0, 3));
            else dat = 8'($urandom());
            frm = '{BYTE_STX, cmd,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom()) : BYTE_LEN_ONE,
                    dat,
                    ($urandom_range(0, 19) == 0) ? 8'($urandom()) : BYTE_ETX};
          end else begin
            frm = '{BYTE_STX, BYTE_STATUS_REQ,
                    ($urandom_range(0, 6) == 0) ? 8'($urandom()) : 8'h00, BYTE_ETX};
          end
        end else if (sel < 75) begin
          case ($urandom_range(0, 6))
            0:       dat = 8'h00;
            1:       dat = 8'hff;
            2:       dat = lo_thr - 8'd1;
            3:       dat = lo_thr;
            4:       dat = hi_thr - 8'd1;
            5:       dat = hi_thr;
            default: dat = 8'($urandom());
          endcase
          send_item(ACT_SAMPLE, dat);
          sent++;
        end else if (sel < 88) begin
          // noise, long enough at times to wrap the write index
          repeat ($urandom_range(1, 7)) frm.push_back(8'($urandom()));
        end else begin
          // truncated command frame
          frm = '{BYTE_STX, 8'($urandom_range(1, 3)), BYTE_LEN_ONE};
          frm = frm[0:$urandom_range(0, 2)];
        end
        foreach (frm[i]) begin
          send_item(ACT_BYTE, frm[i]);
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("PASS fan_command_frame_handler_core");
    end else begin
      $display("FAIL fan_command_frame_handler_core");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/fcfh_pkg.sv
rtl/core/fcfh_ctrl.sv
rtl/core/fcfh_ser.sv
rtl/core/fan_command_frame_handler_core.sv
tb/sv/fan_command_frame_handler_core_tb.sv
